[hdl/ps2l_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 device link package
// Types, codes and helper functions shared by the PS/2 device link modules.
// ----------------------------------------------------------------------------
package ps2l_pkg;

  localparam int unsigned HalfWidth = 10;
  localparam int unsigned LowWidth = 10;
  localparam int unsigned GapWidth = 16;
  localparam int unsigned TimeoutWidth = 20;
  localparam int unsigned CfgDataWidth = 20;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned TickWidth = 20;
  localparam int unsigned BitIndexWidth = 4;

  localparam logic [HalfWidth-1:0] HalfReset = 10'd20;
  localparam logic [LowWidth-1:0] LowReset = 10'd40;
  localparam logic [GapWidth-1:0] GapReset = 16'd100;
  localparam logic [TimeoutWidth-1:0] TimeoutReset = 20'd30000;

  localparam logic [BitIndexWidth-1:0] LastBit = 4'd10;
  localparam logic [BitIndexWidth-1:0] ParityBit = 4'd9;

  localparam logic [CfgIndexWidth-1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_LOW_PERIOD = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_BYTE_GAP = 2'd2;
  localparam logic [CfgIndexWidth-1:0] REG_HOST_TIMEOUT = 2'd3;

  localparam logic [1:0] OP_IDLE = 2'd0;
  localparam logic [1:0] OP_SEND = 2'd1;
  localparam logic [1:0] OP_RECV = 2'd2;

  localparam logic [1:0] TX_SENT = 2'd0;
  localparam logic [1:0] TX_INHIBITED = 2'd1;
  localparam logic [1:0] TX_HOST_REQ = 2'd2;

  localparam logic [1:0] RX_OK = 2'd0;
  localparam logic [1:0] RX_PARITY_ERR = 2'd1;
  localparam logic [1:0] RX_TIMEOUT = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_TX_PRE  = 4'd1,
    PH_TX_BIT  = 4'd2,
    PH_TX_POST = 4'd3,
    PH_RX_WAIT = 4'd4,
    PH_RX_BIT  = 4'd5,
    PH_RX_ACK  = 4'd6
  } phase_t;

  typedef struct packed {
    logic [HalfWidth-1:0]    half_period_ticks;
    logic [LowWidth-1:0]     low_period_ticks;
    logic [GapWidth-1:0]     byte_gap_ticks;
    logic [TimeoutWidth-1:0] host_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic       clk_line;
    logic       data_line;
    logic [7:0] send_byte;
  } in_item_t;

  typedef struct packed {
    logic       clk_pull;
    logic       data_pull;
    logic       busy_res;
    logic       tx_done;
    logic [1:0] tx_status;
    logic       rx_done;
    logic [7:0] rx_byte;
    logic [1:0] rx_status;
  } out_item_t;

  function automatic logic odd_parity(input logic [7:0] value);
    return ~(^value);
  endfunction

endpackage

`default_nettype wire

[hdl/ps2l_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 device link configuration registers
// Holds the timing registers, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module ps2l_cfg_regs
  import ps2l_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data,
  output cfg_t                          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks <= HalfReset;
      cfg.low_period_ticks <= LowReset;
      cfg.byte_gap_ticks <= GapReset;
      cfg.host_timeout_ticks <= TimeoutReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_PERIOD: cfg.half_period_ticks <= cfg_data[HalfWidth-1:0];
        REG_LOW_PERIOD: cfg.low_period_ticks <= cfg_data[LowWidth-1:0];
        REG_BYTE_GAP: cfg.byte_gap_ticks <= cfg_data[GapWidth-1:0];
        REG_HOST_TIMEOUT: cfg.host_timeout_ticks <= cfg_data[TimeoutWidth-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/ps2l_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 device link core
// Link state machine with its tick counter and shift register. Advances one
// tick each time step is high and gives that tick's result.
// ----------------------------------------------------------------------------
module ps2l_core
  import ps2l_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output out_item_t     result
);

  phase_t                   phase, phase_next;
  logic [TickWidth-1:0]     tick_count, tick_count_next;
  logic [BitIndexWidth-1:0] bit_index, bit_index_next;
  logic [7:0]               shift_byte, shift_byte_next;
  logic                     running_parity, running_parity_next;
  logic                     sampled_parity, sampled_parity_next;

  logic [TickWidth:0] tick_ext;
  logic [TickWidth:0] low_start;
  logic [TickWidth:0] low_end;
  logic [TickWidth:0] period;
  logic               clk_low;
  logic               last_tick;
  logic               gap_done;
  logic               timeout_hit;
  logic               host_req;
  logic               tx_bit;
  logic [2:0]         data_pos;

  assign tick_ext = {1'b0, tick_count};
  assign low_start = (TickWidth+1)'(cfg.half_period_ticks);
  assign low_end = low_start + (TickWidth+1)'(cfg.low_period_ticks);
  assign period = low_end + low_start;
  assign clk_low = (tick_ext >= low_start) && (tick_ext < low_end);
  assign last_tick = (tick_ext + (TickWidth+1)'(1)) >= period;
  assign gap_done = tick_count >= TickWidth'(cfg.byte_gap_ticks);
  assign timeout_hit = tick_count >= cfg.host_timeout_ticks;
  assign host_req = !item.data_line && item.clk_line;
  assign data_pos = 3'(bit_index - BitIndexWidth'(1));

  always_comb begin
    case (bit_index) inside
      4'd0: tx_bit = 1'b0;
      [4'd1:4'd8]: tx_bit = shift_byte[data_pos];
      ParityBit: tx_bit = running_parity;
      default: tx_bit = 1'b1;
    endcase
  end

  always_comb begin
    phase_next = phase;
    tick_count_next = tick_count;
    bit_index_next = bit_index;
    shift_byte_next = shift_byte;
    running_parity_next = running_parity;
    sampled_parity_next = sampled_parity;
    case (phase)
      PH_IDLE: begin
        if (item.op == OP_SEND) begin
          shift_byte_next = item.send_byte;
          running_parity_next = odd_parity(item.send_byte);
          tick_count_next = '0;
          bit_index_next = '0;
          phase_next = PH_TX_PRE;
        end else if (item.op == OP_RECV) begin
          tick_count_next = '0;
          bit_index_next = '0;
          phase_next = PH_RX_WAIT;
        end
      end
      PH_TX_PRE: begin
        tick_count_next = '0;
        bit_index_next = '0;
        if (!gap_done) begin
          tick_count_next = tick_count + TickWidth'(1);
        end else if (!item.clk_line || !item.data_line) begin
          phase_next = PH_IDLE;
        end else begin
          phase_next = PH_TX_BIT;
        end
      end
      PH_TX_BIT, PH_RX_BIT: begin
        if (phase == PH_RX_BIT && tick_count == '0) begin
          if (bit_index >= 4'd1 && bit_index <= 4'd8) begin
            if (item.data_line) begin
              shift_byte_next[data_pos] = 1'b1;
              running_parity_next = ~running_parity;
            end
          end else if (bit_index == ParityBit) begin
            sampled_parity_next = item.data_line;
          end
        end
        if (last_tick) begin
          tick_count_next = '0;
          if (bit_index >= LastBit) begin
            phase_next = (phase == PH_TX_BIT) ? PH_TX_POST : PH_RX_ACK;
          end else begin
            bit_index_next = bit_index + BitIndexWidth'(1);
          end
        end else begin
          tick_count_next = tick_count + TickWidth'(1);
        end
      end
      PH_TX_POST: begin
        if (gap_done) begin
          phase_next = PH_IDLE;
          tick_count_next = '0;
          bit_index_next = '0;
        end else begin
          tick_count_next = tick_count + TickWidth'(1);
        end
      end
      PH_RX_WAIT: begin
        if (host_req) begin
          phase_next = PH_RX_BIT;
          tick_count_next = '0;
          bit_index_next = '0;
          shift_byte_next = '0;
          running_parity_next = 1'b1;
          sampled_parity_next = 1'b0;
        end else if (timeout_hit) begin
          phase_next = PH_IDLE;
          tick_count_next = '0;
          bit_index_next = '0;
        end else begin
          tick_count_next = tick_count + TickWidth'(1);
        end
      end
      PH_RX_ACK: begin
        if (last_tick) begin
          phase_next = PH_IDLE;
          tick_count_next = '0;
          bit_index_next = '0;
        end else begin
          tick_count_next = tick_count + TickWidth'(1);
        end
      end
      default: begin
        phase_next = PH_IDLE;
        tick_count_next = '0;
        bit_index_next = '0;
      end
    endcase
  end

  always_comb begin
    result = '0;
    result.busy_res = (phase_next != PH_IDLE);
    case (phase)
      PH_TX_PRE: begin
        if (gap_done && !item.clk_line) begin
          result.tx_done = 1'b1;
          result.tx_status = TX_INHIBITED;
        end else if (gap_done && !item.data_line) begin
          result.tx_done = 1'b1;
          result.tx_status = TX_HOST_REQ;
        end
      end
      PH_TX_BIT: begin
        result.data_pull = ~tx_bit;
        result.clk_pull = clk_low;
      end
      PH_TX_POST: begin
        if (gap_done) begin
          result.tx_done = 1'b1;
          result.tx_status = TX_SENT;
        end
      end
      PH_RX_WAIT: begin
        if (!host_req && timeout_hit) begin
          result.rx_done = 1'b1;
          result.rx_status = RX_TIMEOUT;
        end
      end
      PH_RX_BIT: begin
        result.clk_pull = clk_low;
      end
      PH_RX_ACK: begin
        result.data_pull = 1'b1;
        result.clk_pull = clk_low;
        if (last_tick) begin
          result.rx_done = 1'b1;
          result.rx_byte = shift_byte;
          result.rx_status = (sampled_parity == running_parity) ? RX_OK : RX_PARITY_ERR;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      tick_count <= '0;
      bit_index <= '0;
      shift_byte <= '0;
      running_parity <= 1'b1;
      sampled_parity <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      tick_count <= tick_count_next;
      bit_index <= bit_index_next;
      shift_byte <= shift_byte_next;
      running_parity <= running_parity_next;
      sampled_parity <= sampled_parity_next;
    end
  end

endmodule

`default_nettype wire

[hdl/ps2_device_link_transceiver.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 device link transceiver
// Each request is one tick of the device side of a PS/2 link. The block
// accepts a request every clock cycle unless stalled and returns one result
// per request: each request is held in the input register, then passes once
// through the link state machine into the result register. The state
// machine updates once per request, which sets the rate of one tick per
// cycle while the result side does not stall. Stalls on the result side hold
// the input register and then the input channel.
// ----------------------------------------------------------------------------
module ps2_device_link_transceiver
  import ps2l_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire in_item_t                 in_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output out_item_t                     out_data,
  input  wire logic                     cfg_we,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_q_valid;
  logic      advance;
  logic      in_accept;
  out_item_t result;

  assign advance = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  ps2l_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ps2l_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_q),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

[tb/sv/ps2_device_link_transceiver_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 device link transceiver test
// Drives the transceiver one link tick per request while playing the host on
// the sampled clock and data lines. A cycle-level model of the link state
// machine predicts the result of every tick, and each result is compared
// field by field in order. Directed transfers cover the reset settings, send
// aborts, receive errors, zero periods and the register extremes; random
// transfers follow under three patterns of idling on both channels.
// ----------------------------------------------------------------------------
module ps2_device_link_transceiver_test;
  import ps2l_pkg::*;

  localparam int ClkPeriod = 20;
  localparam int CycleLimit = 1000000;
  localparam int RandomTicks = 70;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  ps2_device_link_transceiver uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cfg_t link_cfg = '{HalfReset, LowReset, GapReset, TimeoutReset};
  phase_t link_phase = PH_IDLE;
  logic [TickWidth-1:0] tick_cnt = '0;
  logic [BitIndexWidth-1:0] bit_idx = '0;
  logic [7:0] frame_byte = '0;
  logic parity_run = 1'b1;
  logic parity_seen = 1'b0;

  logic [1:0] tx_abort_plan = TX_SENT;
  logic [7:0] host_byte = '0;
  logic host_par_bad = 1'b0;
  int host_rts_at = 0;

  out_item_t expected_ticks[$];
  int errors = 0;
  int cycle_count = 0;
  int ticks_sent = 0;
  int pause_at = -1;
  int src_idle_pct = 0;
  int dst_idle_pct = 0;

  always #(ClkPeriod / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < dst_idle_pct);
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_ticks.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got %h", $time, out_data);
        errors++;
      end else begin
        want = expected_ticks.pop_front();
        check_field("clk_pull", 8'(want.clk_pull), 8'(out_data.clk_pull));
        check_field("data_pull", 8'(want.data_pull), 8'(out_data.data_pull));
        check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
        check_field("tx_done", 8'(want.tx_done), 8'(out_data.tx_done));
        check_field("tx_status", 8'(want.tx_status), 8'(out_data.tx_status));
        check_field("rx_done", 8'(want.rx_done), 8'(out_data.rx_done));
        check_field("rx_byte", want.rx_byte, out_data.rx_byte);
        check_field("rx_status", 8'(want.rx_status), 8'(out_data.rx_status));
      end
    end
  end

  // Advances the link model by one tick and queues the result it predicts.
  task automatic link_tick(input in_item_t t);
    out_item_t r;
    logic bit_val;
    logic low_now;
    logic last_tick;
    int half;
    int low;
    int cnt;
    r = '0;
    half = int'(link_cfg.half_period_ticks);
    low = int'(link_cfg.low_period_ticks);
    cnt = int'(tick_cnt);
    low_now = (cnt >= half) && (cnt < half + low);
    last_tick = (cnt + 1 >= 2 * half + low);
    case (link_phase)
      PH_IDLE: begin
        if (t.op == OP_SEND) begin
          frame_byte = t.send_byte;
          parity_run = ~(^t.send_byte);
          tick_cnt = '0;
          bit_idx = '0;
          link_phase = PH_TX_PRE;
        end else if (t.op == OP_RECV) begin
          tick_cnt = '0;
          bit_idx = '0;
          link_phase = PH_RX_WAIT;
        end
      end
      PH_TX_PRE: begin
        if (tick_cnt >= link_cfg.byte_gap_ticks) begin
          if (!t.clk_line) begin
            r.tx_done = 1'b1;
            r.tx_status = TX_INHIBITED;
            link_phase = PH_IDLE;
          end else if (!t.data_line) begin
            r.tx_done = 1'b1;
            r.tx_status = TX_HOST_REQ;
            link_phase = PH_IDLE;
          end else begin
            link_phase = PH_TX_BIT;
          end
          tick_cnt = '0;
          bit_idx = '0;
        end else begin
          tick_cnt++;
        end
      end
      PH_TX_BIT: begin
        if (bit_idx == 0) bit_val = 1'b0;
        else if (bit_idx <= 8) bit_val = frame_byte[bit_idx - 1];
        else if (bit_idx == ParityBit) bit_val = parity_run;
        else bit_val = 1'b1;
        r.data_pull = ~bit_val;
        r.clk_pull = low_now;
        if (last_tick) begin
          tick_cnt = '0;
          if (bit_idx >= LastBit) link_phase = PH_TX_POST;
          else bit_idx++;
        end else begin
          tick_cnt++;
        end
      end
      PH_TX_POST: begin
        if (tick_cnt >= link_cfg.byte_gap_ticks) begin
          r.tx_done = 1'b1;
          r.tx_status = TX_SENT;
          link_phase = PH_IDLE;
          tick_cnt = '0;
          bit_idx = '0;
        end else begin
          tick_cnt++;
        end
      end
      PH_RX_WAIT: begin
        if (!t.data_line && t.clk_line) begin
          link_phase = PH_RX_BIT;
          tick_cnt = '0;
          bit_idx = '0;
          frame_byte = '0;
          parity_run = 1'b1;
          parity_seen = 1'b0;
        end else if (tick_cnt >= link_cfg.host_timeout_ticks) begin
          r.rx_done = 1'b1;
          r.rx_status = RX_TIMEOUT;
          link_phase = PH_IDLE;
          tick_cnt = '0;
          bit_idx = '0;
        end else begin
          tick_cnt++;
        end
      end
      PH_RX_BIT: begin
        if (tick_cnt == 0) begin
          if (bit_idx >= 1 && bit_idx <= 8) begin
            if (t.data_line) begin
              frame_byte[bit_idx - 1] = 1'b1;
              parity_run = ~parity_run;
            end
          end else if (bit_idx == ParityBit) begin
            parity_seen = t.data_line;
          end
        end
        r.clk_pull = low_now;
        if (last_tick) begin
          tick_cnt = '0;
          if (bit_idx >= LastBit) link_phase = PH_RX_ACK;
          else bit_idx++;
        end else begin
          tick_cnt++;
        end
      end
      PH_RX_ACK: begin
        r.data_pull = 1'b1;
        r.clk_pull = low_now;
        if (last_tick) begin
          r.rx_done = 1'b1;
          r.rx_byte = frame_byte;
          r.rx_status = (parity_seen == parity_run) ? RX_OK : RX_PARITY_ERR;
          link_phase = PH_IDLE;
          tick_cnt = '0;
          bit_idx = '0;
        end else begin
          tick_cnt++;
        end
      end
      default: begin
        link_phase = PH_IDLE;
        tick_cnt = '0;
        bit_idx = '0;
      end
    endcase
    r.busy_res = (link_phase != PH_IDLE);
    expected_ticks.push_back(r);
  endtask

  // Plays the host: line levels follow the current plan wherever the block
  // looks at them, and are random noise everywhere else.
  function automatic in_item_t make_tick(input logic [1:0] op, input logic [7:0] b);
    in_item_t t;
    t.op = op;
    t.send_byte = b;
    t.clk_line = 1'($urandom_range(1));
    t.data_line = 1'($urandom_range(1));
    case (link_phase)
      PH_TX_PRE: begin
        if (tick_cnt >= link_cfg.byte_gap_ticks) begin
          if (tx_abort_plan == TX_INHIBITED) begin
            t.clk_line = 1'b0;
          end else begin
            t.clk_line = 1'b1;
            t.data_line = (tx_abort_plan != TX_HOST_REQ);
          end
        end
      end
      PH_RX_WAIT: begin
        if (host_rts_at >= 0 && int'(tick_cnt) >= host_rts_at) begin
          t.clk_line = 1'b1;
          t.data_line = 1'b0;
        end else if (t.clk_line) begin
          t.data_line = 1'b1;
        end
      end
      PH_RX_BIT: begin
        if (tick_cnt == 0) begin
          if (bit_idx == ParityBit) t.data_line = ~(^host_byte) ^ host_par_bad;
          else if (bit_idx >= 1 && bit_idx <= 8) t.data_line = host_byte[bit_idx - 1];
        end
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_ticks.size() != 0);
  endtask

  task automatic send_tick(input in_item_t t);
    if (ticks_sent == pause_at) wait_drained();
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    link_tick(t);
    ticks_sent++;
  endtask

  task automatic put_reg(input logic [CfgIndexWidth-1:0] idx,
                         input logic [CfgDataWidth-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned half, input int unsigned low,
                            input int unsigned gap, input int unsigned timeout);
    wait_drained();
    repeat (4) @(posedge clk);
    put_reg(REG_HALF_PERIOD, CfgDataWidth'(half));
    put_reg(REG_LOW_PERIOD, CfgDataWidth'(low));
    put_reg(REG_BYTE_GAP, CfgDataWidth'(gap));
    put_reg(REG_HOST_TIMEOUT, CfgDataWidth'(timeout));
    cfg_we <= 1'b0;
    link_cfg.half_period_ticks = HalfWidth'(half);
    link_cfg.low_period_ticks = LowWidth'(low);
    link_cfg.byte_gap_ticks = GapWidth'(gap);
    link_cfg.host_timeout_ticks = TimeoutWidth'(timeout);
  endtask

  task automatic idle_ticks(input int n);
    repeat (n) send_tick(make_tick($urandom_range(1) ? OP_RESERVED : OP_IDLE, 8'($urandom)));
  endtask

  task automatic finish_transfer();
    while (link_phase != PH_IDLE) send_tick(make_tick(2'($urandom_range(3)), 8'($urandom)));
  endtask

  task automatic run_send(input logic [7:0] b, input logic [1:0] abort_kind);
    tx_abort_plan = abort_kind;
    send_tick(make_tick(OP_SEND, b));
    finish_transfer();
  endtask

  // A negative request-to-send delay means the host never asks to send.
  task automatic run_recv(input logic [7:0] b, input logic par_bad, input int rts_at);
    host_byte = b;
    host_par_bad = par_bad;
    host_rts_at = rts_at;
    send_tick(make_tick(OP_RECV, 8'($urandom)));
    finish_transfer();
  endtask

  task automatic test_reset_config();
    idle_ticks(3);
    run_send(8'hA5, TX_HOST_REQ);
  endtask

  task automatic test_send_aborts();
    set_config(1, 1, 0, 5);
    run_send(8'h00, TX_SENT);
    run_send(8'hFF, TX_INHIBITED);
    run_send(8'h81, TX_HOST_REQ);
    set_config(0, 2, 4, 5);
    run_send(8'h5A, TX_SENT);
  endtask

  task automatic test_receive_cases();
    set_config(1, 1, 1, 1);
    run_recv(8'hFF, 1'b0, 0);
    run_recv(8'h00, 1'b1, 0);
    run_recv(8'h77, 1'b0, -1);
    set_config(1, 1, 1, 6);
    run_recv(8'h96, 1'b0, 3);
    run_recv(8'h69, 1'b1, 6);
  endtask

  task automatic test_zero_periods();
    set_config(0, 0, 0, 3);
    run_send(8'hC3, TX_SENT);
    run_recv(8'h3C, 1'b0, 1);
    set_config(0, 1, 1, 3);
    run_send(8'h18, TX_SENT);
    run_recv(8'hE1, 1'b1, 2);
    set_config(1, 0, 1, 3);
    run_send(8'h7E, TX_SENT);
    run_recv(8'h81, 1'b0, 0);
  endtask

  task automatic test_config_extremes();
    set_config(1023, 1023, 2, 1048575);
    run_send(8'h42, TX_INHIBITED);
    set_config(1, 1, 0, 1048575);
    run_recv(8'hE7, 1'b0, 2);
    set_config(0, 0, 0, 1);
    run_send(8'h01, TX_SENT);
    run_recv(8'hFE, 1'b0, 1);
  endtask

  task automatic random_config();
    if ($urandom_range(5) == 0) begin
      set_config($urandom_range(0, 6), $urandom_range(0, 8), $urandom_range(0, 6),
                 $urandom_range(1, 12));
    end else begin
      set_config($urandom_range(0, 2), $urandom_range(0, 3), $urandom_range(0, 3),
                 $urandom_range(1, 8));
    end
  endtask

  task automatic random_transfer();
    int pick;
    pick = $urandom_range(9);
    idle_ticks($urandom_range(0, 3));
    if ($urandom_range(99) < 45) begin
      run_send(8'($urandom),
               (pick == 0) ? TX_INHIBITED : (pick == 1) ? TX_HOST_REQ : TX_SENT);
    end else begin
      run_recv(8'($urandom), $urandom_range(9) == 0,
               (pick < 2) ? -1 : int'($urandom_range(0, 4)));
    end
  endtask

  task automatic test_random(input int src_pct, input int dst_pct);
    int stop_at;
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    stop_at = ticks_sent + RandomTicks;
    pause_at = ticks_sent + $urandom_range(20, RandomTicks - 20);
    random_config();
    while (ticks_sent < stop_at) begin
      if ($urandom_range(7) == 0) random_config();
      random_transfer();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_config();
    test_send_aborts();
    test_receive_cases();
    test_zero_periods();
    test_config_extremes();
    test_random(17, 69);
    test_random(69, 17);
    test_random(0, 0);
    wait_drained();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/ps2l_pkg.sv
hdl/ps2l_cfg_regs.sv
hdl/ps2l_core.sv
hdl/ps2_device_link_transceiver.sv
tb/sv/ps2_device_link_transceiver_test.sv
